[design/jds_pkg.sv]
`timescale 1ns / 1ps
package jds_pkg;

    localparam int JDS_FIFO_DEPTH = 8;
    localparam int JDS_IN_W       = 144;
    localparam int JDS_OUT_W      = 96;
    localparam int JDS_RED_BITS   = 20;
    localparam int JDS_CORDIC_N   = 20;
    localparam int JDS_SQRT_N     = 32;
    localparam int JDS_DIV_N      = 18;
    localparam int JDS_HUE_MAX    = 23040;
    localparam int JDS_HUE_ZERO   = 11520;
    localparam int JDS_SAT_ONE    = 65536;
    localparam int JDS_ANG_90     = 90 * 65536;
    localparam int JDS_HUE_OFS    = 180 * 65536 + 512;

    typedef struct packed {
        logic [15:0] tag;
        logic        s0;
        logic        s1;
        logic [19:0] m0;
        logic [19:0] m1;
        logic [39:0] sq0;
        logic [39:0] sq1;
        logic [39:0] sq2;
        logic [39:0] sq3;
    } t_fq;

    localparam int JDS_FQ_W = $bits(t_fq);

    function automatic logic [21:0] jds_atan(input int i);
        logic [21:0] v;
        case (i)
            0:       v = 22'd2949120;
            1:       v = 22'd1740967;
            2:       v = 22'd919879;
            3:       v = 22'd466945;
            4:       v = 22'd234379;
            5:       v = 22'd117304;
            6:       v = 22'd58666;
            7:       v = 22'd29335;
            8:       v = 22'd14668;
            9:       v = 22'd7334;
            10:      v = 22'd3667;
            11:      v = 22'd1833;
            12:      v = 22'd917;
            13:      v = 22'd458;
            14:      v = 22'd229;
            15:      v = 22'd115;
            16:      v = 22'd57;
            17:      v = 22'd29;
            18:      v = 22'd14;
            default: v = 22'd7;
        endcase
        return v;
    endfunction

endpackage

[design/jds_fifo.sv]
`timescale 1ns / 1ps
module jds_fifo
    import jds_pkg::*;
#(
    parameter int DEPTH = JDS_FIFO_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  t_fq                          i_data,
    input  logic                         i_pop,
    output logic                         o_valid,
    output t_fq                          o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_level
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_fq           r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_level = r_cnt;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CW'(DEPTH)) |-> !i_push || i_pop)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("pop from empty queue");
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue level out of range");

endmodule

[design/jds_front.sv]
`timescale 1ns / 1ps
module jds_front
    import jds_pkg::*;
#(
    parameter int DEPTH = JDS_FIFO_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [JDS_IN_W-1:0]         i_data,
    input  logic [$clog2(DEPTH+1)-1:0]  i_level,
    output logic                        o_push,
    output t_fq                         o_data
);
    localparam int CW = $clog2(DEPTH + 1);

    logic              r_v1, r_v2, r_v3;
    logic [15:0]       r_tag1, r_tag2;
    logic              r_s0_1, r_s1_1, r_s0_2, r_s1_2;
    logic [32:0]       r_g [4];
    logic [19:0]       r_m [4];
    t_fq               r_out;
    logic signed [32:0] w_a, w_b, w_c, w_d;
    logic signed [32:0] w_u [4];
    logic [32:0]       w_or;
    logic [3:0]        w_k;
    logic [CW+1:0]     w_busy;
    logic              w_acc;

    assign w_busy  = (CW+2)'(i_level) + (CW+2)'(r_v1) + (CW+2)'(r_v2) + (CW+2)'(r_v3);
    assign o_ready = w_busy < (CW+2)'(DEPTH);
    assign w_acc   = i_valid && o_ready;

    assign w_a = 33'(signed'(i_data[47:16]));
    assign w_b = 33'(signed'(i_data[79:48]));
    assign w_c = 33'(signed'(i_data[111:80]));
    assign w_d = 33'(signed'(i_data[143:112]));
    assign w_u[0] = w_a + w_d;
    assign w_u[1] = w_c - w_b;
    assign w_u[2] = w_a - w_d;
    assign w_u[3] = w_b + w_c;

    assign w_or = r_g[0] | r_g[1] | r_g[2] | r_g[3];

    always_comb begin
        w_k = '0;
        for (int i = JDS_RED_BITS; i < 33; i++) begin
            if (w_or[i]) begin
                w_k = 4'(i - JDS_RED_BITS + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag1 <= i_data[15:0];
        r_s0_1 <= w_u[0][32];
        r_s1_1 <= w_u[1][32];
        for (int i = 0; i < 4; i++) begin
            r_g[i] <= w_u[i][32] ? 33'(-w_u[i]) : 33'(w_u[i]);
            r_m[i] <= 20'(r_g[i] >> w_k);
        end
        r_tag2        <= r_tag1;
        r_s0_2        <= r_s0_1;
        r_s1_2        <= r_s1_1;
        r_out.tag     <= r_tag2;
        r_out.s0      <= r_s0_2;
        r_out.s1      <= r_s1_2;
        r_out.m0      <= r_m[0];
        r_out.m1      <= r_m[1];
        r_out.sq0     <= r_m[0] * r_m[0];
        r_out.sq1     <= r_m[1] * r_m[1];
        r_out.sq2     <= r_m[2] * r_m[2];
        r_out.sq3     <= r_m[3] * r_m[3];
    end

    assign o_push = r_v3;
    assign o_data = r_out;

endmodule

[design/jds_back.sv]
`timescale 1ns / 1ps
module jds_back
    import jds_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_fq                   i_data,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [JDS_OUT_W-1:0]  o_data
);
    localparam int S_PREP = JDS_SQRT_N + 1;
    localparam int NST    = S_PREP + JDS_DIV_N + 1;

    typedef struct packed {
        logic [15:0]            tag;
        logic                   s0;
        logic                   s1;
        logic [19:0]            m0;
        logic [19:0]            m1;
        logic [41:0]            n2;
        logic [40:0]            qq;
        logic [40:0]            pp;
        logic [63:0]            nn;
        logic [63:0]            nr;
        logic [63:0]            hn;
        logic [63:0]            hr;
        logic signed [23:0]     cx;
        logic signed [23:0]     cy;
        logic signed [25:0]     acc;
        logic [3:0][63:0]       rem;
        logic [3:0][17:0]       quo;
    } t_bk;

    t_bk                  r_st [NST];
    t_bk                  n_st [NST];
    logic [NST-1:0]       r_vld;
    logic                 r_ovld;
    logic [JDS_OUT_W-1:0] r_odata;
    logic [JDS_OUT_W-1:0] n_odata;
    logic                 w_en;

    assign w_en  = !r_ovld || i_ready;
    assign o_pop = i_valid && w_en;

    always_comb begin
        logic signed [23:0] x, y;
        n_st[0]     = '0;
        n_st[0].tag = i_data.tag;
        n_st[0].s0  = i_data.s0;
        n_st[0].s1  = i_data.s1;
        n_st[0].m0  = i_data.m0;
        n_st[0].m1  = i_data.m1;
        n_st[0].n2  = 42'(i_data.sq0) + 42'(i_data.sq1) + 42'(i_data.sq2) + 42'(i_data.sq3);
        n_st[0].qq  = 41'(i_data.sq2) + 41'(i_data.sq3);
        n_st[0].pp  = 41'(i_data.sq0) + 41'(i_data.sq1);
        n_st[0].nn  = {2'b0, n_st[0].n2, 20'b0};
        n_st[0].hn  = {3'b0, n_st[0].qq, 20'b0};
        x = i_data.s1 ? -24'(signed'({1'b0, i_data.m1})) : 24'(signed'({1'b0, i_data.m1}));
        y = i_data.s0 ? -24'(signed'({1'b0, i_data.m0})) : 24'(signed'({1'b0, i_data.m0}));
        if (x < 0) begin
            if (y >= 0) begin
                n_st[0].cx  = y;
                n_st[0].cy  = -x;
                n_st[0].acc = 26'(JDS_ANG_90);
            end else begin
                n_st[0].cx  = -y;
                n_st[0].cy  = x;
                n_st[0].acc = -26'(JDS_ANG_90);
            end
        end else begin
            n_st[0].cx = x;
            n_st[0].cy = y;
        end
    end

    for (genvar s = 1; s < NST; s++) begin : g_stage
        if (s <= JDS_SQRT_N) begin : g_sqrt
            localparam int J = s - 1;
            always_comb begin
                logic [63:0]        bt;
                logic signed [23:0] dx, dy;
                logic signed [25:0] at;
                n_st[s] = r_st[s-1];
                bt = 64'(1) << (62 - 2 * J);
                if (r_st[s-1].nn >= r_st[s-1].nr + bt) begin
                    n_st[s].nn = r_st[s-1].nn - (r_st[s-1].nr + bt);
                    n_st[s].nr = (r_st[s-1].nr >> 1) + bt;
                end else begin
                    n_st[s].nr = r_st[s-1].nr >> 1;
                end
                if (r_st[s-1].hn >= r_st[s-1].hr + bt) begin
                    n_st[s].hn = r_st[s-1].hn - (r_st[s-1].hr + bt);
                    n_st[s].hr = (r_st[s-1].hr >> 1) + bt;
                end else begin
                    n_st[s].hr = r_st[s-1].hr >> 1;
                end
                dx = r_st[s-1].cy >>> J;
                dy = r_st[s-1].cx >>> J;
                at = 26'(signed'({1'b0, jds_atan(J)}));
                if (J < JDS_CORDIC_N) begin
                    if (r_st[s-1].cy > 0) begin
                        n_st[s].cx  = r_st[s-1].cx + dx;
                        n_st[s].cy  = r_st[s-1].cy - dy;
                        n_st[s].acc = r_st[s-1].acc + at;
                    end else begin
                        n_st[s].cx  = r_st[s-1].cx - dx;
                        n_st[s].cy  = r_st[s-1].cy + dy;
                        n_st[s].acc = r_st[s-1].acc - at;
                    end
                end
            end
        end else if (s == S_PREP) begin : g_prep
            always_comb begin
                n_st[s] = r_st[s-1];
                n_st[s].rem[0] = {19'b0, r_st[s-1].m0, 25'b0} + (r_st[s-1].nr >> 1);
                n_st[s].rem[1] = {19'b0, r_st[s-1].m1, 25'b0} + (r_st[s-1].nr >> 1);
                n_st[s].rem[2] = (r_st[s-1].hr << 15) + (r_st[s-1].nr >> 1);
                n_st[s].rem[3] = {7'b0, r_st[s-1].pp, 16'b0} + 64'(r_st[s-1].n2 >> 1);
                n_st[s].quo    = '0;
            end
        end else begin : g_div
            localparam int B = JDS_DIV_N - 1 - (s - S_PREP - 1);
            always_comb begin
                logic [63:0] dv;
                n_st[s] = r_st[s-1];
                for (int k = 0; k < 4; k++) begin
                    dv = (k == 3) ? 64'(r_st[s-1].n2) << B : r_st[s-1].nr << B;
                    if (r_st[s-1].rem[k] >= dv) begin
                        n_st[s].rem[k]    = r_st[s-1].rem[k] - dv;
                        n_st[s].quo[k][B] = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        t_bk                f;
        logic [17:0]        qc;
        logic [15:0]        dvp, rtp;
        logic [14:0]        shp, hue;
        logic [16:0]        sat;
        logic signed [26:0] ha;
        f  = r_st[NST-1];
        qc = '0;
        if (f.s0) begin
            qc  = (f.quo[0] > 18'd32768) ? 18'd32768 : f.quo[0];
            dvp = 16'(18'd0 - qc);
        end else begin
            dvp = (f.quo[0] > 18'd32767) ? 16'd32767 : f.quo[0][15:0];
        end
        if (f.s1) begin
            qc  = (f.quo[1] > 18'd32768) ? 18'd32768 : f.quo[1];
            rtp = 16'(18'd0 - qc);
        end else begin
            rtp = (f.quo[1] > 18'd32767) ? 16'd32767 : f.quo[1][15:0];
        end
        shp = (f.quo[2] > 18'd32767) ? 15'd32767 : f.quo[2][14:0];
        sat = (f.quo[3] > 18'(JDS_SAT_ONE)) ? 17'(JDS_SAT_ONE) : f.quo[3][16:0];
        ha  = 27'(f.acc) + 27'(JDS_HUE_OFS);
        if (ha < 0) begin
            hue = '0;
        end else if (ha[26:10] > 17'(JDS_HUE_MAX)) begin
            hue = 15'(JDS_HUE_MAX);
        end else begin
            hue = ha[24:10];
        end
        if (f.n2 == '0) begin
            dvp = '0;
            rtp = '0;
            shp = '0;
            hue = 15'(JDS_HUE_ZERO);
            sat = 17'(JDS_SAT_ONE);
        end
        n_odata = {1'b0, sat, hue, shp, rtp, dvp, f.tag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[NST-2:0], i_valid};
            r_ovld <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < NST; s++) begin
                r_st[s] <= n_st[s];
            end
            r_odata <= n_odata;
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_odata;

endmodule

[design/jacobian_decomposition_hue_saturation.sv]
`timescale 1ns / 1ps
// Splits one vertex's 2x2 Q16.16 Jacobian into normalized divergence and
// rotation (Q1.15), shear (Q0.15), a hue in 1/64 degree and a Q1.16
// saturation. One beat is taken per cycle while the queue has room, and one
// result beat leaves per cycle while the output is not stalled. A three-stage
// front end reduces and squares the terms and feeds a small queue; the back
// end is a 52-stage pipeline (two 32-step square roots running beside a
// 20-step CORDIC, then four 18-step long divisions) plus an output register.
// Output back pressure stalls the back end only; the front keeps accepting
// while the queue has room.
module jacobian_decomposition_hue_saturation
    import jds_pkg::*;
#(
    parameter int FIFO_DEPTH = JDS_FIFO_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // vertex_id, jac_a, jac_b, jac_c, jac_d
    input  logic [JDS_IN_W-1:0]   i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // vertex_tag, div_part, rot_part, shear_part, hue, saturation, pad
    output logic [JDS_OUT_W-1:0]  o_m_axis_tdata
);
    logic                            w_push, w_pop, w_qv;
    t_fq                             w_fd, w_qd;
    logic [$clog2(FIFO_DEPTH+1)-1:0] w_level;

    jds_front #(.DEPTH(FIFO_DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_level (w_level),
        .o_push  (w_push),
        .o_data  (w_fd)
    );

    jds_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fd),
        .i_pop   (w_pop),
        .o_valid (w_qv),
        .o_data  (w_qd),
        .o_level (w_level)
    );

    jds_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qv),
        .i_data  (w_qd),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule
